>>> hw/rtl/owtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtq_pkg
// Types and constants shared by the one-wire temperature reading qualifier.
// ----------------------------------------------------------------------------
package owtq_pkg;

    localparam int NUM_SENSORS_DEF = 16;

    // scratchpad shape
    localparam int PAD_W    = 64;
    localparam int CRC_W    = 8;
    localparam int RAW_W    = 16;
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = PAD_W / DIGIT_W;
    localparam int DCOUNT_W = $clog2(DIGITS);

    localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

    // field widths
    localparam int SENSOR_W = 4;
    localparam int TEMP_W   = 20;
    localparam int LIMIT_W  = 8;
    localparam int THR_W    = 16;
    localparam int NUDGE_W  = 12;
    localparam int MASK_W   = 16;
    localparam int FC_W     = 8;

    // fixed point conversion: raw*9 + 2560 in 1/80 degree F
    localparam logic signed [TEMP_W-1:0] F80_OFFSET = 20'sd2560;

    // reset values
    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST = 8'd10;
    localparam logic [THR_W-1:0]   JUMP_THR_RST   = 16'd400;
    localparam logic [NUDGE_W-1:0] JUMP_NUDGE_RST = 12'd40;
    localparam logic [MASK_W-1:0]  PRESENT_RST    = 16'hFFFF;
    localparam logic [FC_W-1:0]    FAIL_COUNT_RST = 8'd10;
    localparam logic [FC_W-1:0]    FAIL_COUNT_MAX = 8'd255;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_FAIL_LIMIT = 2'd0,
        REG_JUMP_THR   = 2'd1,
        REG_JUMP_NUDGE = 2'd2,
        REG_PRESENT    = 2'd3
    } reg_idx_t;

    localparam logic KIND_READING  = 1'b0;
    localparam logic KIND_BUS_FAIL = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [SENSOR_W-1:0] sensor;
        logic [PAD_W-1:0]    pad_bytes;
        logic [CRC_W-1:0]    pad_crc;
    } item_t;

    typedef struct packed {
        logic [SENSOR_W-1:0]      out_sensor;
        logic signed [TEMP_W-1:0] temp_f80;
        logic                     temp_known;
        logic                     crc_ok;
        logic                     all_known;
    } result_t;

    // status of the serial crc unit
    typedef struct packed {
        logic busy;
        logic done;
        logic match;
    } crc_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/owtq_crc8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtq_crc8
// Digit-serial Dallas CRC-8 check: shifts the scratchpad out one nibble per
// cycle, LSB first, and compares the final CRC with the received byte.
// ----------------------------------------------------------------------------
module owtq_crc8 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [owtq_pkg::PAD_W-1:0]  data,
    input  wire logic [owtq_pkg::CRC_W-1:0]  crc_rx,
    output owtq_pkg::crc_stat_t              stat
);

    logic [owtq_pkg::PAD_W-1:0]    shift_reg;
    logic [owtq_pkg::CRC_W-1:0]    crc_reg;
    logic [owtq_pkg::CRC_W-1:0]    crc_next;
    logic [owtq_pkg::CRC_W-1:0]    exp_reg;
    logic [owtq_pkg::DCOUNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          match_reg;

    // one nibble of the reflected crc, four dependent bit steps
    always_comb
    begin
        logic [owtq_pkg::CRC_W-1:0] c;
        logic                       mix;
        c = crc_reg;
        for (int k = 0; k < owtq_pkg::DIGIT_W; k++)
        begin
            mix = c[0] ^ shift_reg[k];
            c   = c >> 1;
            if (mix)
            begin
                c = c ^ owtq_pkg::CRC_POLY;
            end
        end
        crc_next = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            match_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == owtq_pkg::DCOUNT_W'(owtq_pkg::DIGITS - 1))
                begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    match_reg <= (crc_next == exp_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= data;
            crc_reg   <= '0;
            exp_reg   <= crc_rx;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg >> owtq_pkg::DIGIT_W;
            crc_reg   <= crc_next;
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign stat.match = match_reg;

endmodule
`default_nettype wire

>>> hw/rtl/onewire_temp_reading_qualifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_temp_reading_qualifier
// Checks one-wire scratchpad readings, converts good ones to 1/80 degree F
// and tracks per-sensor known state and fail counts.
// ----------------------------------------------------------------------------
// One word in, one word out, one at a time. For a scratchpad reading the CRC
// unit shifts the 64 scratchpad bits through one nibble per cycle, followed
// by the conversion, jump check, store and result read. A reading for an
// absent sensor skips straight to the result read. A bus-failure word walks
// the fail count memory one sensor at a time (read, then write back). A new
// word is taken as soon as the previous result sits in the output register,
// even while that result is still stalled.
module onewire_temp_reading_qualifier #(
    parameter int NUM_SENSORS = owtq_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [owtq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [owtq_pkg::PDATA_W-1:0]  pwdata,
    output logic      [owtq_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire owtq_pkg::item_t               item,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output owtq_pkg::result_t                  result
);

    localparam int IW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int TW = owtq_pkg::TEMP_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_CRC  = 10'b00_0000_0010,
        S_BAD  = 10'b00_0000_0100,
        S_CONV = 10'b00_0000_1000,
        S_DIFF = 10'b00_0001_0000,
        S_JUMP = 10'b00_0010_0000,
        S_FRD  = 10'b00_0100_0000,
        S_FWR  = 10'b00_1000_0000,
        S_SHOW = 10'b01_0000_0000,
        S_RES  = 10'b10_0000_0000
    } state_t;

    // configuration
    logic [owtq_pkg::LIMIT_W-1:0] fail_limit_reg;
    logic [owtq_pkg::THR_W-1:0]   jump_thr_reg;
    logic [owtq_pkg::NUDGE_W-1:0] jump_nudge_reg;
    logic [owtq_pkg::MASK_W-1:0]  present_reg;
    logic                         cfg_we;
    owtq_pkg::reg_idx_t           cfg_idx;

    // control
    state_t                        state_reg, state_next;
    logic [IW-1:0]                 sidx_reg, sidx_next;
    logic [owtq_pkg::SENSOR_W-1:0] show_reg, show_next;
    logic                          show_in_reg, show_in_next;
    logic                          crc_ok_reg, crc_ok_next;
    logic [NUM_SENSORS-1:0]        known_reg, known_next;
    logic [NUM_SENSORS-1:0]        temp_vld_reg, temp_vld_next;
    logic [NUM_SENSORS-1:0]        fc_vld_reg, fc_vld_next;
    logic                          result_valid_reg, result_valid_next;

    // datapath
    logic [owtq_pkg::RAW_W-1:0]    raw_reg, raw_next;
    logic signed [TW-1:0]          val_reg, val_next;
    logic signed [TW:0]            diff_reg, diff_next;
    owtq_pkg::result_t             result_reg, result_next;

    // memories
    logic [TW-1:0]                 temp_mem [NUM_SENSORS];
    logic [owtq_pkg::FC_W-1:0]     fc_mem   [NUM_SENSORS];
    logic [TW-1:0]                 temp_rd_reg;
    logic [owtq_pkg::FC_W-1:0]     fc_rd_reg;
    logic                          temp_rdv_reg;
    logic                          fc_rdv_reg;
    logic [IW-1:0]                 rd_addr;
    logic [IW-1:0]                 wr_addr;
    logic                          temp_we;
    logic [TW-1:0]                 temp_wdata;
    logic                          fc_we;
    logic [owtq_pkg::FC_W-1:0]     fc_wdata;

    logic                          crc_start;
    owtq_pkg::crc_stat_t           crc_stat;

    logic                          accept;
    logic                          sensor_ok;
    logic signed [TW-1:0]          prev_temp;
    logic [owtq_pkg::FC_W-1:0]     fc_cur;
    logic [owtq_pkg::FC_W-1:0]     fc_inc;
    logic signed [TW+1:0]          diff_x;
    logic signed [TW+1:0]          thr_x;
    logic signed [TW-1:0]          nudge_x;
    logic signed [TW-1:0]          raw_x;

    owtq_crc8 u_crc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (crc_start),
        .data   (item.pad_bytes),
        .crc_rx (item.pad_crc),
        .stat   (crc_stat)
    );

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = owtq_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            owtq_pkg::REG_FAIL_LIMIT: prdata = owtq_pkg::PDATA_W'(fail_limit_reg);
            owtq_pkg::REG_JUMP_THR:   prdata = owtq_pkg::PDATA_W'(jump_thr_reg);
            owtq_pkg::REG_JUMP_NUDGE: prdata = owtq_pkg::PDATA_W'(jump_nudge_reg);
            owtq_pkg::REG_PRESENT:    prdata = owtq_pkg::PDATA_W'(present_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg <= owtq_pkg::FAIL_LIMIT_RST;
            jump_thr_reg   <= owtq_pkg::JUMP_THR_RST;
            jump_nudge_reg <= owtq_pkg::JUMP_NUDGE_RST;
            present_reg    <= owtq_pkg::PRESENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                owtq_pkg::REG_FAIL_LIMIT: fail_limit_reg <= pwdata[owtq_pkg::LIMIT_W-1:0];
                owtq_pkg::REG_JUMP_THR:   jump_thr_reg   <= pwdata[owtq_pkg::THR_W-1:0];
                owtq_pkg::REG_JUMP_NUDGE: jump_nudge_reg <= pwdata[owtq_pkg::NUDGE_W-1:0];
                owtq_pkg::REG_PRESENT:    present_reg    <= pwdata[owtq_pkg::MASK_W-1:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sensor memories, registered read; valid bits stand in for reset values
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (temp_we)
        begin
            temp_mem[wr_addr] <= temp_wdata;
        end
        if (fc_we)
        begin
            fc_mem[wr_addr] <= fc_wdata;
        end
        temp_rd_reg  <= temp_mem[rd_addr];
        fc_rd_reg    <= fc_mem[rd_addr];
        temp_rdv_reg <= temp_vld_reg[rd_addr];
        fc_rdv_reg   <= fc_vld_reg[rd_addr];
    end

    assign prev_temp = temp_rdv_reg ? signed'(temp_rd_reg) : '0;
    assign fc_cur    = fc_rdv_reg ? fc_rd_reg : owtq_pkg::FAIL_COUNT_RST;
    assign fc_inc    = (fc_cur == owtq_pkg::FAIL_COUNT_MAX) ? fc_cur : fc_cur + 1'b1;

    assign accept    = item_valid && !item_stall;
    assign sensor_ok = (32'(item.sensor) < NUM_SENSORS) && present_reg[item.sensor];
    assign raw_x     = TW'(signed'(raw_reg));
    assign diff_x    = {diff_reg[TW], diff_reg};
    assign thr_x     = signed'({{(TW + 2 - owtq_pkg::THR_W){1'b0}}, jump_thr_reg});
    assign nudge_x   = signed'({{(TW - owtq_pkg::NUDGE_W){1'b0}}, jump_nudge_reg});

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        sidx_next         = sidx_reg;
        show_next         = show_reg;
        show_in_next      = show_in_reg;
        crc_ok_next       = crc_ok_reg;
        known_next        = known_reg;
        temp_vld_next     = temp_vld_reg;
        fc_vld_next       = fc_vld_reg;
        result_valid_next = result_valid_reg;
        raw_next          = raw_reg;
        val_next          = val_reg;
        diff_next         = diff_reg;
        result_next       = result_reg;
        crc_start         = 1'b0;
        rd_addr           = sidx_reg;
        wr_addr           = sidx_reg;
        temp_we           = 1'b0;
        temp_wdata        = val_reg;
        fc_we             = 1'b0;
        fc_wdata          = fc_inc;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    crc_ok_next = 1'b0;
                    raw_next    = item.pad_bytes[owtq_pkg::RAW_W-1:0];
                    if (item.kind == owtq_pkg::KIND_BUS_FAIL)
                    begin
                        show_next    = '0;
                        show_in_next = 1'b1;
                        sidx_next    = '0;
                        state_next   = S_FRD;
                    end
                    else
                    begin
                        show_next    = item.sensor;
                        show_in_next = (32'(item.sensor) < NUM_SENSORS);
                        sidx_next    = IW'(item.sensor);
                        if (sensor_ok)
                        begin
                            crc_start  = 1'b1;
                            state_next = S_CRC;
                        end
                        else
                        begin
                            state_next = S_SHOW;
                        end
                    end
                end
            end
            S_CRC:
            begin
                if (crc_stat.done)
                begin
                    state_next = crc_stat.match ? S_CONV : S_BAD;
                end
            end
            S_BAD:
            begin
                if (fc_cur >= fail_limit_reg)
                begin
                    known_next[sidx_reg] = 1'b0;
                end
                else
                begin
                    fc_we                 = 1'b1;
                    fc_vld_next[sidx_reg] = 1'b1;
                end
                state_next = S_SHOW;
            end
            S_CONV:
            begin
                // raw*9 as raw*8 + raw
                val_next   = (raw_x <<< 3) + raw_x + owtq_pkg::F80_OFFSET;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                diff_next  = {val_reg[TW-1], val_reg} - {prev_temp[TW-1], prev_temp};
                state_next = S_JUMP;
            end
            S_JUMP:
            begin
                temp_wdata = val_reg;
                if (known_reg[sidx_reg] && (diff_x > thr_x))
                begin
                    temp_wdata = val_reg + nudge_x;
                end
                else if (known_reg[sidx_reg] && (diff_x < -thr_x))
                begin
                    temp_wdata = val_reg - nudge_x;
                end
                temp_we                 = 1'b1;
                fc_we                   = 1'b1;
                fc_wdata                = '0;
                temp_vld_next[sidx_reg] = 1'b1;
                fc_vld_next[sidx_reg]   = 1'b1;
                known_next[sidx_reg]    = 1'b1;
                crc_ok_next             = 1'b1;
                state_next              = S_SHOW;
            end
            S_FRD:
            begin
                state_next = S_FWR;
            end
            S_FWR:
            begin
                fc_we                 = 1'b1;
                fc_vld_next[sidx_reg] = 1'b1;
                if (fc_inc > fail_limit_reg)
                begin
                    known_next[sidx_reg] = 1'b0;
                end
                sidx_next = sidx_reg + 1'b1;
                if (sidx_reg == IW'(NUM_SENSORS - 1))
                begin
                    sidx_next  = '0;
                    state_next = S_SHOW;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_SHOW:
            begin
                rd_addr    = IW'(show_reg);
                state_next = S_RES;
            end
            S_RES:
            begin
                rd_addr = IW'(show_reg);
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.out_sensor = show_reg;
                    result_next.temp_f80   = show_in_reg ? prev_temp : '0;
                    result_next.temp_known = show_in_reg && known_reg[IW'(show_reg)];
                    result_next.crc_ok     = crc_ok_reg;
                    result_next.all_known  = &known_reg;
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sidx_reg         <= '0;
            show_reg         <= '0;
            show_in_reg      <= 1'b0;
            crc_ok_reg       <= 1'b0;
            known_reg        <= '0;
            temp_vld_reg     <= '0;
            fc_vld_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sidx_reg         <= sidx_next;
            show_reg         <= show_next;
            show_in_reg      <= show_in_next;
            crc_ok_reg       <= crc_ok_next;
            known_reg        <= known_next;
            temp_vld_reg     <= temp_vld_next;
            fc_vld_reg       <= fc_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= raw_next;
        val_reg    <= val_next;
        diff_reg   <= diff_next;
        result_reg <= result_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/owtq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtq_checker
// Port-level checks for the one-wire temperature reading qualifier.
// ----------------------------------------------------------------------------
module owtq_checker #(
    parameter int NUM_SENSORS = owtq_pkg::NUM_SENSORS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire owtq_pkg::result_t result
);

    // a held result keeps its word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // one word in flight: the input closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input open right after accept");

    // a good reading leaves its sensor known
    a_crc_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.crc_ok |-> result.temp_known)
        else $error("crc ok without known temperature");

    // all known covers the reported sensor when it exists
    a_all_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.all_known && (32'(result.out_sensor) < NUM_SENSORS)
        |-> result.temp_known)
        else $error("all known but reported sensor unknown");

endmodule

bind onewire_temp_reading_qualifier owtq_checker #(
    .NUM_SENSORS (NUM_SENSORS)
) u_owtq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: one-wire temperature reading qualifier bench
// Sends scratchpad readings and bus-failure words through the valid/stall
// input, predicts each result from a local model of the sensor table and
// compares every output word field by field. Random idling on both sides,
// register settings changed between phases over the APB-style port.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import owtq_pkg::*;

    localparam int N_SENS      = NUM_SENSORS_DEF;
    localparam int CYCLE_LIMIT = 500000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                item_valid = 1'b0;
    logic                item_stall;
    item_t               item = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_t             result;

    onewire_temp_reading_qualifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // register copies
    logic [LIMIT_W-1:0]       limit_cfg;
    logic [THR_W-1:0]         thr_cfg;
    logic [NUDGE_W-1:0]       nudge_cfg;
    logic [MASK_W-1:0]        mask_cfg;

    // sensor table copy
    logic signed [TEMP_W-1:0] temp_tab [N_SENS];
    logic [N_SENS-1:0]        known_bits;
    logic [FC_W-1:0]          fail_tab [N_SENS];

    logic [RAW_W-1:0]         last_raw [N_SENS];
    result_t                  pending_results [$];
    result_t                  want_r;
    int                       errors = 0;
    int                       cycles = 0;
    bit                       quiet = 1'b0;

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [CRC_W-1:0] dallas_crc(logic [PAD_W-1:0] bytes);
        logic [CRC_W-1:0] c;
        logic             mix;
        c = '0;
        for (int i = 0; i < PAD_W; i++) begin
            mix = c[0] ^ bytes[i];
            c = c >> 1;
            if (mix)
                c = c ^ 8'h8C;
        end
        return c;
    endfunction

    // updates the sensor table for one accepted word and returns its result
    function automatic result_t qualify_word(item_t w);
        result_t          r;
        int               val;
        int               prev;
        logic [SENSOR_W-1:0] show;
        logic             ok;
        ok = 1'b0;
        if (w.kind == KIND_BUS_FAIL) begin
            for (int i = 0; i < N_SENS; i++) begin
                if (fail_tab[i] != FAIL_COUNT_MAX)
                    fail_tab[i] = fail_tab[i] + 1'b1;
                if (fail_tab[i] > limit_cfg)
                    known_bits[i] = 1'b0;
            end
            show = '0;
        end else begin
            show = w.sensor;
            if (mask_cfg[w.sensor]) begin
                if (dallas_crc(w.pad_bytes) != w.pad_crc) begin
                    if (fail_tab[w.sensor] >= limit_cfg)
                        known_bits[w.sensor] = 1'b0;
                    else
                        fail_tab[w.sensor] = fail_tab[w.sensor] + 1'b1;
                end else begin
                    val = int'($signed(w.pad_bytes[RAW_W-1:0])) * 9 + 2560;
                    if (known_bits[w.sensor]) begin
                        prev = int'(temp_tab[w.sensor]);
                        if (val > prev + int'(thr_cfg))
                            val = val + int'(nudge_cfg);
                        else if (val < prev - int'(thr_cfg))
                            val = val - int'(nudge_cfg);
                    end
                    temp_tab[w.sensor]   = val[TEMP_W-1:0];
                    known_bits[w.sensor] = 1'b1;
                    fail_tab[w.sensor]   = '0;
                    ok = 1'b1;
                end
            end
        end
        r.out_sensor = show;
        r.temp_f80   = temp_tab[show];
        r.temp_known = known_bits[show];
        r.crc_ok     = ok;
        r.all_known  = &known_bits;
        return r;
    endfunction

    function automatic item_t reading(logic [SENSOR_W-1:0] s, logic [RAW_W-1:0] raw,
                                      bit good, logic [PAD_W-1:0] fill);
        item_t w;
        w.kind      = KIND_READING;
        w.sensor    = s;
        w.pad_bytes = {fill[PAD_W-1:RAW_W], raw};
        w.pad_crc   = dallas_crc(w.pad_bytes);
        if (!good)
            w.pad_crc = w.pad_crc ^ CRC_W'($urandom_range(1, 255));
        return w;
    endfunction

    function automatic item_t bus_fail_word();
        item_t w;
        w.kind      = KIND_BUS_FAIL;
        w.sensor    = SENSOR_W'($urandom);
        w.pad_bytes = {$urandom, $urandom};
        w.pad_crc   = CRC_W'($urandom);
        return w;
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw(logic [SENSOR_W-1:0] s);
        case ($urandom_range(0, 6))
            0, 1, 2: return last_raw[s] + RAW_W'($urandom_range(0, 120)) - 16'd60;
            3:       return last_raw[s] + RAW_W'($urandom_range(0, 4)) - 16'd2;
            4:       return RAW_W'($urandom);
            5:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: return RAW_W'($urandom_range(0, 2000)) - 16'd500;
        endcase
    endfunction

    task automatic send_word(item_t w);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge clk);
                item_valid = 1'b0;
            end
        end
        @(negedge clk);
        item_valid = 1'b1;
        item       = w;
        do @(posedge clk); while (item_stall);
        pending_results.push_back(qualify_word(w));
    endtask

    task automatic send_good(logic [SENSOR_W-1:0] s, logic [RAW_W-1:0] raw);
        send_word(reading(s, raw, 1'b1, {$urandom, $urandom}));
        last_raw[s] = raw;
    endtask

    // lets every expected word come out, then a little slack
    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        case (idx)
            REG_FAIL_LIMIT: begin
                data[LIMIT_W-1:0] = val[LIMIT_W-1:0];
                limit_cfg = val[LIMIT_W-1:0];
            end
            REG_JUMP_THR: begin
                data[THR_W-1:0] = val[THR_W-1:0];
                thr_cfg = val[THR_W-1:0];
            end
            REG_JUMP_NUDGE: begin
                data[NUDGE_W-1:0] = val[NUDGE_W-1:0];
                nudge_cfg = val[NUDGE_W-1:0];
            end
            default: begin
                data[MASK_W-1:0] = val[MASK_W-1:0];
                mask_cfg = val[MASK_W-1:0];
            end
        endcase
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic setup(int lim, int thr, int nudge, int mask);
        write_reg(REG_FAIL_LIMIT, lim);
        write_reg(REG_JUMP_THR, thr);
        write_reg(REG_JUMP_NUDGE, nudge);
        write_reg(REG_PRESENT, mask);
    endtask

    task automatic run_mix(int count, int bus_pct, int bad_pct);
        int               n;
        int               roll;
        int               burst;
        logic [SENSOR_W-1:0] s;
        n = 0;
        while (n < count) begin
            s    = SENSOR_W'($urandom_range(0, N_SENS - 1));
            roll = $urandom_range(0, 99);
            if (roll < bus_pct) begin
                send_word(bus_fail_word());
                n++;
            end else if (roll < bus_pct + bad_pct) begin
                // run of corrupt readings on one sensor to walk its fail count
                burst = $urandom_range(1, 12);
                repeat (burst)
                    send_word(reading(s, pick_raw(s), 1'b0, {$urandom, $urandom}));
                n += burst;
            end else begin
                send_good(s, pick_raw(s));
                n++;
            end
        end
    endtask

    task automatic test_directed();
        logic [RAW_W-1:0] edge_raw [4];
        edge_raw = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        for (int i = 0; i < 4; i++) begin
            send_word(reading(SENSOR_W'(i), edge_raw[i], 1'b1, (i % 2 == 0) ? '1 : '0));
            last_raw[i] = edge_raw[i];
        end
        for (int i = 4; i < N_SENS; i++)
            send_good(SENSOR_W'(i), RAW_W'($urandom_range(0, 1600)));
        // all sensors known from here on
        send_good(4'd0, 16'h0000);
        send_good(4'd2, 16'h0100);
        send_good(4'd5, last_raw[5] + 16'd1);
        send_word(reading(4'd6, last_raw[6], 1'b0, {$urandom, $urandom}));
        send_word(reading(4'd15, 16'h1234, 1'b0, '1));
        send_word(bus_fail_word());
        send_word('{kind: KIND_BUS_FAIL, sensor: 4'hF, pad_bytes: '1, pad_crc: '1});
        drain();
    endtask

    task automatic test_extreme_limits();
        setup(0, 0, 4095, 16'hFFFF);
        run_mix(250, 6, 15);
        drain();
    endtask

    task automatic test_wide_threshold();
        setup(255, 65535, 0, $urandom_range(0, 65535));
        run_mix(200, 4, 12);
        drain();
    endtask

    task automatic test_saturation();
        // every sensor absent, so only bus failures move the fail counts
        setup(254, 400, 40, 16'h0000);
        for (int i = 0; i < 275; i++) begin
            if (i % 11 == 5)
                send_word(reading(SENSOR_W'($urandom_range(0, N_SENS - 1)), RAW_W'($urandom),
                                  1'($urandom_range(0, 1)), {$urandom, $urandom}));
            else
                send_word(bus_fail_word());
        end
        drain();
        write_reg(REG_PRESENT, 16'hFFFF);
        send_word(reading(4'd3, 16'h0200, 1'b0, {$urandom, $urandom}));
        send_good(4'd4, 16'h0190);
        send_word(bus_fail_word());
        drain();
        write_reg(REG_FAIL_LIMIT, 255);
        send_word(reading(4'd7, 16'h0050, 1'b0, {$urandom, $urandom}));
        send_word(bus_fail_word());
        for (int i = 0; i < N_SENS; i++)
            send_good(SENSOR_W'(i), pick_raw(SENSOR_W'(i)));
        drain();
    endtask

    task automatic test_mixed();
        setup(3, 100, 1000, 16'hDFFF);
        run_mix(150, 5, 20);
        drain();
        write_reg(REG_PRESENT, 16'hFFFF);
        run_mix(100, 3, 10);
        drain();
    endtask

    task automatic test_steady_flow();
        setup(10, 400, 40, 16'hFFFF);
        quiet = 1'b1;
        run_mix(300, 3, 10);
        drain();
    endtask

    // receiver stalls in bursts, with some long free stretches
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 24);
            repeat (n) begin
                @(negedge clk);
                result_stall = 1'b0;
            end
            if (!quiet && $urandom_range(0, 1) == 0) begin
                n = $urandom_range(1, 16);
                repeat (n) begin
                    @(negedge clk);
                    result_stall = !quiet;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with none expected: %h", result);
                errors++;
            end else begin
                want_r = pending_results.pop_front();
                if (result.out_sensor !== want_r.out_sensor) begin
                    $error("out_sensor: expected %0d, got %0d", want_r.out_sensor,
                           result.out_sensor);
                    errors++;
                end
                if (result.temp_f80 !== want_r.temp_f80) begin
                    $error("temp_f80: expected %0d, got %0d", want_r.temp_f80,
                           result.temp_f80);
                    errors++;
                end
                if (result.temp_known !== want_r.temp_known) begin
                    $error("temp_known: expected %0d, got %0d", want_r.temp_known,
                           result.temp_known);
                    errors++;
                end
                if (result.crc_ok !== want_r.crc_ok) begin
                    $error("crc_ok: expected %0d, got %0d", want_r.crc_ok, result.crc_ok);
                    errors++;
                end
                if (result.all_known !== want_r.all_known) begin
                    $error("all_known: expected %0d, got %0d", want_r.all_known,
                           result.all_known);
                    errors++;
                end
            end
        end
    end

    initial begin
        limit_cfg  = FAIL_LIMIT_RST;
        thr_cfg    = JUMP_THR_RST;
        nudge_cfg  = JUMP_NUDGE_RST;
        mask_cfg   = PRESENT_RST;
        known_bits = '0;
        for (int i = 0; i < N_SENS; i++) begin
            temp_tab[i] = '0;
            fail_tab[i] = FAIL_COUNT_RST;
            last_raw[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_extreme_limits();
        test_wide_threshold();
        test_saturation();
        test_mixed();
        test_steady_flow();

        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
